/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the waveform decimator.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle, outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/mmwd_pkg.sv */
// Package for the min/max waveform decimator: widths, reset values,
// register indexes and the point/job types passed between units.
`timescale 1ns / 1ps

package mmwd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COL_W    = 15;
  localparam int IDX_W    = 24;
  localparam int XOFF_W   = 14;
  localparam int HH_W     = 12;
  localparam int Y_W      = 13;
  localparam int CFG_W    = 24;
  localparam int SCALE_SH = 15;  // divide by full scale 32768
  localparam int PROD_W   = SAMPLE_W + HH_W + 1;
  localparam int MAX_PTS  = 3;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int DIV_CNT_W = $clog2(COL_W + 1);

  localparam logic [COL_W-1:0]  WIDTH_RST = COL_W'(1024);
  localparam logic [IDX_W-1:0]  COUNT_RST = IDX_W'(1024);
  localparam logic [XOFF_W-1:0] XOFF_RST  = '0;
  localparam logic [HH_W-1:0]   HH_RST    = HH_W'(128);
  // width / count and width % count for the reset register values
  localparam logic [COL_W-1:0]  QUO_RST   = COL_W'(1);
  localparam logic [IDX_W-1:0]  REM_RST   = '0;

  typedef enum logic [1:0] {
    CFG_DISPLAY_WIDTH = 2'd0,
    CFG_SAMPLE_COUNT  = 2'd1,
    CFG_X_OFFSET      = 2'd2,
    CFG_HALF_HEIGHT   = 2'd3
  } cfg_idx_e;

  // One display point before scaling; baseline points carry value zero.
  typedef struct packed {
    logic [COL_W-1:0]           col;
    logic signed [SAMPLE_W-1:0] val;
    logic                       last;
  } point_t;

  // All points caused by one item, in emission order.
  typedef struct packed {
    logic [1:0]               npts;
    point_t [MAX_PTS-1:0]     pts;
  } job_t;

  // Column step derived from the configuration.
  typedef struct packed {
    logic [COL_W-1:0] quo;
    logic [IDX_W-1:0] rem;
    logic             busy;
  } div_res_t;

endpackage

/* rtl/mmwd_div.sv */
// Restoring divider: display_width / sample_count and remainder, one
// quotient bit per cycle. Depends on mmwd_pkg.
`timescale 1ns / 1ps

module mmwd_div import mmwd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [COL_W-1:0] width_i,
  input  logic [IDX_W-1:0] n_i,
  output div_res_t         res_o
);

  logic [COL_W-1:0]     dvd_q, dvd_d;
  logic [IDX_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic [IDX_W:0]       trial, diff;
  logic                 ge;

  always_comb begin
    trial  = {rem_q, dvd_q[COL_W-1]};
    diff   = trial - {1'b0, n_i};
    ge     = trial >= {1'b0, n_i};
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      dvd_d  = width_i;
      rem_d  = '0;
      cnt_d  = DIV_CNT_W'(COL_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[COL_W-2:0], ge};
      rem_d = ge ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= QUO_RST;
      rem_q  <= REM_RST;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      dvd_q  <= dvd_d;
      rem_q  <= rem_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign res_o = '{quo: dvd_q, rem: rem_q, busy: busy_q};

endmodule

/* rtl/mmwd_front.sv */
// Front end: takes samples, tracks column stepping and min/max, and turns
// each sample into a job of up to three points. Depends on mmwd_pkg.
`timescale 1ns / 1ps

module mmwd_front import mmwd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [COL_W-1:0]           width_i,
  input  logic [IDX_W-1:0]           n_i,
  input  div_res_t                   div_i,
  output logic                       push_o,
  output job_t                       job_o
);

  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [COL_W-1:0]           col_now_q, col_now_d;
  logic [COL_W-1:0]           col_prev_q, col_prev_d;
  logic [IDX_W-1:0]           acc_q, acc_d;
  logic signed [SAMPLE_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic                       open_q, open_d;

  logic                       decim, close, rec_end;
  logic signed [SAMPLE_W-1:0] lo_u, hi_u;
  logic [IDX_W-1:0]           sum;
  logic [1:0]                 k;
  point_t [MAX_PTS-1:0]       pts;

  always_comb begin
    decim      = {{(IDX_W-COL_W){1'b0}}, width_i} < n_i;
    close      = col_now_q > col_prev_q;
    rec_end    = idx_q >= (n_i - IDX_W'(1));
    lo_u       = (!open_q || sample_i < lo_q) ? sample_i : lo_q;
    hi_u       = (!open_q || sample_i > hi_q) ? sample_i : hi_q;
    sum        = acc_q + div_i.rem;
    idx_d      = idx_q;
    col_now_d  = col_now_q;
    col_prev_d = col_prev_q;
    acc_d      = acc_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    open_d     = open_q;
    pts        = '0;
    k          = 2'd0;

    if (decim) begin
      lo_d   = lo_u;
      hi_d   = hi_u;
      open_d = 1'b1;
      if (close) begin
        if (lo_u > 0 && hi_u > 0) begin
          pts[k] = '{col: col_prev_q, val: hi_u, last: 1'b0};
          k      = k + 2'd1;
        end else if (lo_u < 0 && hi_u < 0) begin
          pts[k] = '{col: col_prev_q, val: lo_u, last: 1'b0};
          k      = k + 2'd1;
        end else begin
          pts[k] = '{col: col_prev_q, val: lo_u, last: 1'b0};
          k      = k + 2'd1;
          pts[k] = '{col: col_prev_q, val: hi_u, last: 1'b0};
          k      = k + 2'd1;
        end
        open_d     = 1'b0;
        lo_d       = '0;
        hi_d       = '0;
        col_prev_d = col_now_q;
      end
    end else begin
      pts[k]     = '{col: col_prev_q, val: sample_i, last: 1'b0};
      k          = k + 2'd1;
      col_prev_d = col_now_q;
    end

    if (rec_end) begin
      if (decim && open_d) begin
        pts[k] = '{col: col_prev_d, val: lo_d, last: 1'b0};
        k      = k + 2'd1;
        pts[k] = '{col: col_prev_d, val: hi_d, last: 1'b0};
        k      = k + 2'd1;
      end
      // baseline point: value zero scales to the baseline row
      pts[k]     = '{col: col_prev_d, val: '0, last: 1'b1};
      k          = k + 2'd1;
      idx_d      = '0;
      col_now_d  = '0;
      col_prev_d = '0;
      acc_d      = '0;
      lo_d       = '0;
      hi_d       = '0;
      open_d     = 1'b0;
    end else begin
      idx_d = idx_q + IDX_W'(1);
      if (sum >= n_i) begin
        acc_d     = sum - n_i;
        col_now_d = col_now_q + div_i.quo + COL_W'(1);
      end else begin
        acc_d     = sum;
        col_now_d = col_now_q + div_i.quo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      col_now_q  <= '0;
      col_prev_q <= '0;
      acc_q      <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      open_q     <= 1'b0;
    end else if (accept_i) begin
      idx_q      <= idx_d;
      col_now_q  <= col_now_d;
      col_prev_q <= col_prev_d;
      acc_q      <= acc_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      open_q     <= open_d;
    end
  end

  assign push_o = accept_i && (k != 2'd0);
  assign job_o  = '{npts: k, pts: pts};

endmodule

/* rtl/mmwd_fifo.sv */
// Short job queue between front and back end. Depends on mmwd_pkg.
`timescale 1ns / 1ps

module mmwd_fifo import mmwd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic empty_o,
  output logic full_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  function automatic logic [QPTR_W-1:0] nxt(input logic [QPTR_W-1:0] p);
    nxt = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= nxt(wr_q);
      end
      if (pop_i) begin
        rd_q <= nxt(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  assign head_o  = mem_q[rd_q];
  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == QCNT_W'(QDEPTH);

endmodule

/* rtl/mmwd_back.sv */
// Back end: walks the points of each queued job, scales the value to a
// display row and holds the result in the output register. Depends on mmwd_pkg.
`timescale 1ns / 1ps

module mmwd_back import mmwd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  job_t              head_i,
  input  logic              empty_i,
  output logic              pop_o,
  input  logic [XOFF_W-1:0] xoff_i,
  input  logic [HH_W-1:0]   hh_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [COL_W-1:0]  out_x_pos_o,
  output logic [Y_W-1:0]    out_y_pos_o,
  output logic              out_last_point_o
);

  logic [1:0]               ptr_q;
  logic                     m_valid_q;
  logic signed [PROD_W-1:0] m_prod_q;
  logic [COL_W-1:0]         m_col_q;
  logic                     m_last_q;
  logic                     out_valid_q;
  logic [COL_W-1:0]         out_x_q;
  logic [Y_W-1:0]           out_y_q;
  logic                     out_last_q;

  logic                     out_free, m_free, issue;
  point_t                   cur;
  logic signed [PROD_W-1:0] prod;
  logic signed [Y_W:0]      q_row, y_full;

  always_comb begin
    out_free = !out_valid_q || !out_stall_i;
    m_free   = !m_valid_q || out_free;
    issue    = !empty_i && m_free;
    cur      = head_i.pts[ptr_q];
    pop_o    = issue && (ptr_q == head_i.npts - 2'd1);
    prod     = $signed(cur.val) * $signed({1'b0, hh_i});
    // floor division by full scale is an arithmetic shift
    q_row    = (Y_W + 1)'(m_prod_q >>> SCALE_SH);
    y_full   = $signed({2'b00, hh_i}) - q_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        ptr_q <= pop_o ? 2'd0 : ptr_q + 2'd1;
      end
      if (m_free) begin
        m_valid_q <= issue;
      end
      if (out_free) begin
        out_valid_q <= m_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      m_prod_q <= prod;
      m_col_q  <= cur.col;
      m_last_q <= cur.last;
    end
    if (out_free && m_valid_q) begin
      out_x_q    <= m_col_q + {{(COL_W-XOFF_W){1'b0}}, xoff_i};
      out_y_q    <= y_full[Y_W-1:0];
      out_last_q <= m_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_x_pos_o      = out_x_q;
  assign out_y_pos_o      = out_y_q;
  assign out_last_point_o = out_last_q;

endmodule

/* rtl/min_max_waveform_decimator_core.sv */
// Min/max peak-detect waveform decimator: top level with config registers.
// Depends on mmwd_pkg, mmwd_div, mmwd_front, mmwd_fifo, mmwd_back, assert_macros.svh.
// Usage:
//  - Input channel: one signed 16-bit sample per item (in_valid_i/in_stall_o).
//  - Output channel: display points x_pos, y_pos, last_point
//    (out_valid_o/out_stall_i); zero to three points per sample.
//  - Config channel: cfg_index_i selects display_width, sample_count,
//    x_offset, half_height; written when cfg_valid_i and cfg_ready_o.
//  - Path: each point passes the job queue, product and output registers.
//  - Throughput: the back end emits one point per cycle while out_stall_i
//    is low, and a sample yields zero to three points; the two-entry job
//    queue smooths this. One-sample records at zero display width yield
//    three points per sample.
//  - A write to display_width or sample_count starts a restoring division
//    for the column step; in_stall_o and !cfg_ready_o hold from the
//    registered start until the divider is done.
//  - Reset: registers go to 1024/1024/0/128, the record restarts empty;
//    the column step for the reset values is preloaded, no stall.
//  - When the receiver stalls, the output point holds, the job queue
//    fills and in_stall_o rises once the queue is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module min_max_waveform_decimator_core import mmwd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // sample input
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] in_sample_i,
  // point output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [COL_W-1:0]           out_x_pos_o,
  output logic [Y_W-1:0]             out_y_pos_o,
  output logic                       out_last_point_o,
  // configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_data_i
);

  logic [COL_W-1:0]  width_q;
  logic [IDX_W-1:0]  count_q;
  logic [XOFF_W-1:0] xoff_q;
  logic [HH_W-1:0]   hh_q;
  logic              div_start_q;

  logic              cfg_we, accept, div_hold;
  logic [IDX_W-1:0]  n_eff;
  div_res_t          div_res;
  logic              push, pop, q_empty, q_full;
  job_t              push_job, head_job;

  // zero sample count behaves as a one-sample record
  assign n_eff    = (count_q == '0) ? IDX_W'(1) : count_q;
  assign div_hold = div_start_q || div_res.busy;
  assign cfg_ready_o = !div_hold;
  assign cfg_we   = cfg_valid_i && cfg_ready_o;
  assign in_stall_o = q_full || div_hold;
  assign accept   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WIDTH_RST;
      count_q     <= COUNT_RST;
      xoff_q      <= XOFF_RST;
      hh_q        <= HH_RST;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (cfg_we) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_DISPLAY_WIDTH: begin
            width_q     <= cfg_data_i[COL_W-1:0];
            div_start_q <= 1'b1;
          end
          CFG_SAMPLE_COUNT: begin
            count_q     <= cfg_data_i[IDX_W-1:0];
            div_start_q <= 1'b1;
          end
          CFG_X_OFFSET: begin
            xoff_q <= cfg_data_i[XOFF_W-1:0];
          end
          CFG_HALF_HEIGHT: begin
            hh_q <= cfg_data_i[HH_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  mmwd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .width_i (width_q),
    .n_i     (n_eff),
    .res_o   (div_res)
  );

  mmwd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (in_sample_i),
    .width_i  (width_q),
    .n_i      (n_eff),
    .div_i    (div_res),
    .push_o   (push),
    .job_o    (push_job)
  );

  mmwd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .head_o  (head_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  mmwd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head_job),
    .empty_i          (q_empty),
    .pop_o            (pop),
    .xoff_i           (xoff_q),
    .hh_i             (hh_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_x_pos_o      (out_x_pos_o),
    .out_y_pos_o      (out_y_pos_o),
    .out_last_point_o (out_last_point_o)
  );

  // closing point of a record always sits on the baseline row
  `ASSERT_IMPLIES(a_last_on_baseline, clk_i, rst_ni, (out_valid_o && out_last_point_o), (out_y_pos_o == {1'b0, hh_q}), "last point off baseline")
  // column step remainder stays below the divisor once division is done
  `ASSERT_IMPLIES(a_div_rem_range, clk_i, rst_ni, !div_hold, (div_res.rem < n_eff), "column step remainder out of range")
  // quotient and remainder reproduce the display width
  `ASSERT_IMPLIES(a_div_exact, clk_i, rst_ni, !div_hold, (({24'd0, div_res.quo} * {15'd0, n_eff}) + {15'd0, div_res.rem} == {24'd0, width_q}), "column step division wrong")

endmodule
